[rtl/fpd_pkg.sv]
// Package for the flipper PI drive: constants, register indexes, shared types.
package fpd_pkg;

	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 16;

	localparam logic [CfgIdxW-1:0] REG_PROP_GAIN  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_INTEG_GAIN = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_INTEG_LIM  = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_PWM_SCALE  = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_STEP_SIZE  = 3'd4;

	localparam logic [15:0] PROP_GAIN_RST  = 16'd256;
	localparam logic [15:0] INTEG_GAIN_RST = 16'd26;
	localparam logic [14:0] INTEG_LIM_RST  = 15'd10000;
	localparam logic [15:0] PWM_SCALE_RST  = 16'd2560;
	localparam logic [9:0]  STEP_SIZE_RST  = 10'd100;

	localparam logic [15:0] DECAY_Q16 = 16'd60964;
	localparam logic signed [42:0] CORR_LIMIT = 43'sd1000;
	localparam logic signed [27:0] PWM_CENTRE = 28'sd37000;
	localparam logic signed [27:0] PWM_MAX = 28'sd65535;

	typedef struct packed {
		logic [15:0] prop_gain;
		logic [15:0] integ_gain;
		logic [14:0] integral_limit;
		logic [15:0] pwm_scale;
		logic [9:0]  step_size;
	} cfg_t;

	typedef struct packed {
		logic               load;
		logic signed [24:0] a;
		logic signed [16:0] b;
	} mul_req_t;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_DECAY = 8'b0000_0010,
		ST_INTEG = 8'b0000_0100,
		ST_PMUL  = 8'b0000_1000,
		ST_IMUL  = 8'b0001_0000,
		ST_CORR  = 8'b0010_0000,
		ST_OMUL  = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

endpackage

[rtl/fpd_if.sv]
// Channel interfaces for the drive command beats and the PWM compare beats.
interface fpd_cmd_if;
	logic valid;
	logic ready;
	logic direction;
	logic drive_enable;

	modport source (output valid, output direction, output drive_enable, input ready);
	modport sink (input valid, input direction, input drive_enable, output ready);
endinterface

interface fpd_pwm_if;
	logic        valid;
	logic        ready;
	logic [15:0] pwm_compare;

	modport source (output valid, output pwm_compare, input ready);
	modport sink (input valid, input pwm_compare, output ready);
endinterface

[rtl/flipper_pi_drive.sv]
// Top level of the flipper PI drive: configuration registers and unit wiring.
// Usage:
// The drive_in channel takes one beat per control tick, carrying direction and
// drive_enable. For each accepted beat exactly one beat leaves on pwm_out with
// the new PWM compare value, where 37000 means the motor is stopped.
// Gains, the integral limit, the PWM scale and the step size are written
// through cfg_we, cfg_index and cfg_wdata while the block is idle; an index
// beyond the register list is ignored.
// Each beat runs through the decay, integral, proportional multiply, integral
// multiply, correction, output multiply and output steps, sharing the one
// multiplier that serves the integral decay, both gain products and the
// output scaling in turn.
// drive_in.ready is high only while the sequencer is idle.
// The result sits in an output register, so the next input beat is accepted
// while a result still waits; if the receiver stalls, the following result
// is held back in the final step until the register is free.
// Reset clears the integral and loads the default register values.
module flipper_pi_drive (
	input  logic                                clk,
	input  logic                                arst_n,
	fpd_cmd_if.sink                             drive_in,
	fpd_pwm_if.source                           pwm_out,
	input  logic                                cfg_we,
	input  logic [fpd_pkg::CfgIdxW-1:0]         cfg_index,
	input  logic [fpd_pkg::CfgDataW-1:0]        cfg_wdata
);
	import fpd_pkg::*;

	cfg_t               cfg_q;
	mul_req_t           mul_req;
	logic signed [41:0] prod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain <= PROP_GAIN_RST;
			cfg_q.integ_gain <= INTEG_GAIN_RST;
			cfg_q.integral_limit <= INTEG_LIM_RST;
			cfg_q.pwm_scale <= PWM_SCALE_RST;
			cfg_q.step_size <= STEP_SIZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROP_GAIN:  cfg_q.prop_gain <= cfg_wdata;
				REG_INTEG_GAIN: cfg_q.integ_gain <= cfg_wdata;
				REG_INTEG_LIM:  cfg_q.integral_limit <= cfg_wdata[14:0];
				REG_PWM_SCALE:  cfg_q.pwm_scale <= cfg_wdata;
				REG_STEP_SIZE:  cfg_q.step_size <= cfg_wdata[9:0];
				default: begin
				end
			endcase
		end
	end

	fpd_mul u_mul (
		.clk    (clk),
		.req    (mul_req),
		.prod_q (prod_q)
	);

	fpd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (drive_in.valid),
		.in_ready     (drive_in.ready),
		.direction    (drive_in.direction),
		.drive_enable (drive_in.drive_enable),
		.out_valid    (pwm_out.valid),
		.out_ready    (pwm_out.ready),
		.pwm_compare  (pwm_out.pwm_compare),
		.mul_req      (mul_req),
		.prod         (prod_q)
	);
endmodule

[rtl/fpd_mul.sv]
// Shared signed multiplier with a registered product.
module fpd_mul (
	input  logic               clk,
	input  fpd_pkg::mul_req_t  req,
	output logic signed [41:0] prod_q
);
	import fpd_pkg::*;

	logic signed [41:0] prod_d;

	assign prod_d = $signed(req.a) * $signed(req.b);

	always_ff @(posedge clk) begin
		if (req.load) begin
			prod_q <= prod_d;
		end
	end
endmodule

[rtl/fpd_ctrl.sv]
// Sequencer and datapath: integral update, correction and PWM saturation.
module fpd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  fpd_pkg::cfg_t      cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               direction,
	input  logic               drive_enable,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        pwm_compare,
	output fpd_pkg::mul_req_t  mul_req,
	input  logic signed [41:0] prod
);
	import fpd_pkg::*;

	state_t             state_q;
	logic               dir_q;
	logic               en_q;
	logic signed [23:0] acc_q;
	logic signed [42:0] sum_q;
	logic signed [10:0] corr_q;
	logic [15:0]        pwm_q;
	logic               out_valid_q;

	logic signed [10:0] step_ext;
	logic signed [10:0] err;
	logic [23:0]        acc_mag;
	logic signed [23:0] mag_dec;
	logic signed [23:0] dec;
	logic signed [23:0] base;
	logic signed [24:0] acc_sum;
	logic signed [24:0] lim_pos;
	logic signed [24:0] lim_neg;
	logic signed [24:0] acc_clamp;
	logic signed [42:0] total;
	logic signed [42:0] total_rnd;
	logic signed [42:0] quot;
	logic signed [10:0] corr_d;
	logic signed [27:0] scaled;
	logic signed [27:0] scaled_rnd;
	logic signed [27:0] pwm_full;
	logic [15:0]        pwm_d;
	logic               out_free;

	assign step_ext = $signed({1'b0, cfg.step_size});
	assign err = en_q ? (dir_q ? step_ext : -step_ext) : 11'sd0;

	assign acc_mag = acc_q[23] ? 24'(-acc_q) : 24'(acc_q);
	assign mag_dec = $signed({1'b0, prod[38:16]});
	assign dec = acc_q[23] ? -mag_dec : mag_dec;
	assign base = en_q ? acc_q : dec;
	assign acc_sum = {base[23], base} + $signed({{6{err[10]}}, err, 8'b0});
	assign lim_pos = $signed({2'b00, cfg.integral_limit, 8'b0});
	assign lim_neg = -lim_pos;

	always_comb begin
		if (acc_sum > lim_pos) begin
			acc_clamp = lim_pos;
		end else if (acc_sum < lim_neg) begin
			acc_clamp = lim_neg;
		end else begin
			acc_clamp = acc_sum;
		end
	end

	assign total = sum_q + {prod[41], prod};
	assign total_rnd = total + (total[42] ? 43'sd65535 : 43'sd0);
	assign quot = total_rnd >>> 16;

	always_comb begin
		if (quot > CORR_LIMIT) begin
			corr_d = 11'(CORR_LIMIT);
		end else if (quot < -CORR_LIMIT) begin
			corr_d = 11'(-CORR_LIMIT);
		end else begin
			corr_d = quot[10:0];
		end
	end

	assign scaled = $signed(prod[27:0]);
	assign scaled_rnd = (scaled + (scaled[27] ? 28'sd255 : 28'sd0)) >>> 8;
	assign pwm_full = scaled_rnd + PWM_CENTRE;

	always_comb begin
		if (pwm_full < 28'sd0) begin
			pwm_d = '0;
		end else if (pwm_full > PWM_MAX) begin
			pwm_d = '1;
		end else begin
			pwm_d = pwm_full[15:0];
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		mul_req.load = 1'b0;
		mul_req.a = '0;
		mul_req.b = '0;
		unique case (state_q)
			ST_DECAY: begin
				mul_req.load = 1'b1;
				mul_req.a = $signed({1'b0, acc_mag});
				mul_req.b = $signed({1'b0, DECAY_Q16});
			end
			ST_PMUL: begin
				mul_req.load = 1'b1;
				mul_req.a = $signed({{14{err[10]}}, err});
				mul_req.b = $signed({1'b0, cfg.prop_gain});
			end
			ST_IMUL: begin
				mul_req.load = 1'b1;
				mul_req.a = $signed({acc_q[23], acc_q});
				mul_req.b = $signed({1'b0, cfg.integ_gain});
			end
			ST_OMUL: begin
				mul_req.load = 1'b1;
				mul_req.a = $signed({{14{corr_q[10]}}, corr_q});
				mul_req.b = $signed({1'b0, cfg.pwm_scale});
			end
			default: begin
				mul_req.load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			acc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DECAY;
					end
				end
				ST_DECAY: state_q <= ST_INTEG;
				ST_INTEG: begin
					acc_q <= acc_clamp[23:0];
					state_q <= ST_PMUL;
				end
				ST_PMUL: state_q <= ST_IMUL;
				ST_IMUL: state_q <= ST_CORR;
				ST_CORR: state_q <= ST_OMUL;
				ST_OMUL: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			dir_q <= direction;
			en_q <= drive_enable;
		end
		if (state_q == ST_IMUL) begin
			sum_q <= $signed({prod[34:0], 8'b0});
		end
		if (state_q == ST_CORR) begin
			corr_q <= corr_d;
		end
		if (state_q == ST_OUT && out_free) begin
			pwm_q <= pwm_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign pwm_compare = pwm_q;
endmodule

[rtl/fpd_checker.sv]
// Port-level assertions for the flipper PI drive, bound to the top level.
module fpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] pwm_compare
);

	// Once a beat is taken, in_ready stays low while the sequencer works through the beat.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready
			##1 !in_ready ##1 !in_ready ##1 !in_ready)
		else $error("input accepted while the previous beat was still in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pwm_compare))
		else $error("stalled result beat changed or vanished");

	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result beat withdrawn without being taken");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result beat offered during reset");

endmodule

bind flipper_pi_drive fpd_checker u_fpd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (drive_in.valid),
	.in_ready    (drive_in.ready),
	.out_valid   (pwm_out.valid),
	.out_ready   (pwm_out.ready),
	.pwm_compare (pwm_out.pwm_compare)
);

[dv/tb_flipper_pi_drive.sv]
// Self-checking testbench for the flipper PI drive: directed table, random drive runs, stalls.
module tb_flipper_pi_drive;
	timeunit 1ns;
	timeprecision 1ps;

	import fpd_pkg::*;

	localparam int HALF_PERIOD = 2;
	localparam int RESET_CYCLES = 5;
	localparam int IDLE_PCT = 38;
	localparam int HOLD_CYCLES = 200;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 12;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES = 8;
	localparam int BEATS_PER_PHASE = 46;

	localparam longint DECAY_RECIP_Q16 = 60964;
	localparam longint CORR_CLAMP = 1000;
	localparam longint PWM_STOPPED = 37000;
	localparam longint PWM_TOP = 65535;

	localparam logic [CfgIdxW-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_SPARE_HI = 3'd7;

	typedef enum logic [1:0] {
		ROW_BEAT,
		ROW_WRITE
	} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic [CfgIdxW-1:0] idx;
		logic [15:0]        data;
		logic               dir;
		logic               en;
		logic               pinned;
		logic [15:0]        pwm;
	} row_t;

	typedef struct {
		logic [15:0] pwm;
		int unsigned seq;
	} pwm_due_t;

	localparam int STEER_N = 39;
	localparam row_t STEER_ROWS [0:STEER_N-1] = '{
		'{ROW_BEAT,  REG_PROP_GAIN,  16'h0000, 1'b0, 1'b0, 1'b1, 16'd37000},
		'{ROW_BEAT,  REG_PROP_GAIN,  16'h0000, 1'b1, 1'b0, 1'b1, 16'd37000},
		'{ROW_BEAT,  REG_PROP_GAIN,  16'h0000, 1'b1, 1'b1, 1'b0, 16'd0},
		'{ROW_BEAT,  REG_PROP_GAIN,  16'h0000, 1'b1, 1'b1, 1'b0, 16'd0},
		'{ROW_BEAT,  REG_PROP_GAIN,  16'h0000, 1'b0, 1'b1, 1'b0, 16'd0},
		'{ROW_BEAT,  REG_PROP_GAIN,  16'h0000, 1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_WRITE, REG_PROP_GAIN,  16'hFFFF, 1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_WRITE, REG_INTEG_GAIN, 16'hFFFF, 1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_WRITE, REG_INTEG_LIM,  16'h7FFF, 1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_WRITE, REG_PWM_SCALE,  16'hFFFF, 1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_WRITE, REG_STEP_SIZE,  16'h03FF, 1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_BEAT,  REG_PROP_GAIN,  16'h0000, 1'b1, 1'b1, 1'b1, 16'd65535},
		'{ROW_BEAT,  REG_PROP_GAIN,  16'h0000, 1'b0, 1'b1, 1'b1, 16'd0},
		'{ROW_BEAT,  REG_PROP_GAIN,  16'h0000, 1'b0, 1'b1, 1'b1, 16'd0},
		'{ROW_BEAT,  REG_PROP_GAIN,  16'h0000, 1'b1, 1'b0, 1'b0, 16'd0},
		'{ROW_WRITE, REG_INTEG_LIM,  16'h0000, 1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_WRITE, REG_PROP_GAIN,  16'h0000, 1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_WRITE, REG_PWM_SCALE,  16'd256,  1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_BEAT,  REG_PROP_GAIN,  16'h0000, 1'b1, 1'b1, 1'b1, 16'd37000},
		'{ROW_BEAT,  REG_PROP_GAIN,  16'h0000, 1'b0, 1'b1, 1'b1, 16'd37000},
		'{ROW_BEAT,  REG_PROP_GAIN,  16'h0000, 1'b1, 1'b0, 1'b1, 16'd37000},
		'{ROW_WRITE, REG_INTEG_GAIN, 16'h0000, 1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_WRITE, REG_STEP_SIZE,  16'h0000, 1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_WRITE, REG_INTEG_LIM,  16'h0001, 1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_BEAT,  REG_PROP_GAIN,  16'h0000, 1'b1, 1'b1, 1'b1, 16'd37000},
		'{ROW_WRITE, REG_SPARE_LO,   16'hFFFF, 1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_WRITE, REG_SPARE_HI,   16'hFFFF, 1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_WRITE, REG_STEP_SIZE,  16'hFFFF, 1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_WRITE, REG_INTEG_LIM,  16'hFFFF, 1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_WRITE, REG_PROP_GAIN,  16'd256,  1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_WRITE, REG_INTEG_GAIN, 16'd26,   1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_WRITE, REG_PWM_SCALE,  16'd2560, 1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_BEAT,  REG_PROP_GAIN,  16'h0000, 1'b1, 1'b1, 1'b0, 16'd0},
		'{ROW_BEAT,  REG_PROP_GAIN,  16'h0000, 1'b1, 1'b1, 1'b0, 16'd0},
		'{ROW_BEAT,  REG_PROP_GAIN,  16'h0000, 1'b1, 1'b1, 1'b0, 16'd0},
		'{ROW_BEAT,  REG_PROP_GAIN,  16'h0000, 1'b0, 1'b1, 1'b0, 16'd0},
		'{ROW_BEAT,  REG_PROP_GAIN,  16'h0000, 1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_BEAT,  REG_PROP_GAIN,  16'h0000, 1'b0, 1'b0, 1'b0, 16'd0},
		'{ROW_BEAT,  REG_PROP_GAIN,  16'h0000, 1'b1, 1'b0, 1'b0, 16'd0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgDataW-1:0] cfg_wdata;

	fpd_cmd_if drive_ch ();
	fpd_pwm_if pwm_ch ();

	int kp_q88;
	int ki_q88;
	int integ_lim;
	int pwm_scale_q88;
	int step_mag;
	longint integ_q8;

	pwm_due_t pwm_due_q [$];
	pwm_due_t due_head;

	bit src_idle;
	bit snk_idle;
	bit hold_req;
	int unsigned beats_sent;
	int unsigned results_seen;
	int unsigned writes_done;
	int unsigned mismatches;
	int unsigned quiet_cycles;

	flipper_pi_drive i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.drive_in  (drive_ch),
		.pwm_out   (pwm_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #HALF_PERIOD clk = ~clk;

	task automatic report(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic logic [15:0] pi_next_pwm(input logic dir, input logic en);
		longint err;
		longint acc;
		longint mag;
		longint lim;
		longint corr;
		longint pwm;
		err = 0;
		acc = integ_q8;
		lim = longint'(integ_lim) * 256;
		if (en) begin
			err = dir ? longint'(step_mag) : -longint'(step_mag);
		end else begin
			mag = (acc < 0) ? -acc : acc;
			mag = (mag * DECAY_RECIP_Q16) >>> 16;
			acc = (acc < 0) ? -mag : mag;
		end
		acc = acc + err * 256;
		if (acc > lim) acc = lim;
		if (acc < -lim) acc = -lim;
		integ_q8 = acc;
		corr = (longint'(kp_q88) * err * 256 + longint'(ki_q88) * acc) / 65536;
		if (corr > CORR_CLAMP) corr = CORR_CLAMP;
		if (corr < -CORR_CLAMP) corr = -CORR_CLAMP;
		pwm = corr * longint'(pwm_scale_q88) / 256 + PWM_STOPPED;
		if (pwm < 0) pwm = 0;
		if (pwm > PWM_TOP) pwm = PWM_TOP;
		return pwm[15:0];
	endfunction

	function automatic logic [15:0] pick_cfg(input int unsigned top, input int unsigned rst);
		case ($urandom_range(5))
			0: begin
				return 16'(0);
			end
			1: begin
				return 16'(top);
			end
			2: begin
				return 16'(rst);
			end
			3: begin
				return 16'($urandom_range(top / 32));
			end
			default: begin
				return 16'($urandom);
			end
		endcase
	endfunction

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_PROP_GAIN: begin
				kp_q88 = int'(data);
			end
			REG_INTEG_GAIN: begin
				ki_q88 = int'(data);
			end
			REG_INTEG_LIM: begin
				integ_lim = int'(data & 16'h7FFF);
			end
			REG_PWM_SCALE: begin
				pwm_scale_q88 = int'(data);
			end
			REG_STEP_SIZE: begin
				step_mag = int'(data & 16'h03FF);
			end
			default: begin
			end
		endcase
		writes_done++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_beat(input logic dir, input logic en, input logic pinned,
			input logic [15:0] pinned_pwm);
		pwm_due_t due;
		if (src_idle && $urandom_range(99) < IDLE_PCT) begin
			drive_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
		end
		drive_ch.valid <= 1'b1;
		drive_ch.direction <= dir;
		drive_ch.drive_enable <= en;
		do @(posedge clk); while (!drive_ch.ready);
		due.pwm = pi_next_pwm(dir, en);
		if (pinned) due.pwm = pinned_pwm;
		due.seq = beats_sent;
		pwm_due_q.push_back(due);
		beats_sent++;
	endtask

	task automatic settle();
		drive_ch.valid <= 1'b0;
		while (pwm_due_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Receiver: random back-pressure, plus one long hold-off on request.
	initial begin
		pwm_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				pwm_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				pwm_ch.ready <= snk_idle ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && pwm_ch.valid && pwm_ch.ready) begin
			results_seen++;
			if (pwm_due_q.size() == 0) begin
				report($sformatf("pwm_compare %0d arrived with nothing expected",
					pwm_ch.pwm_compare));
			end else begin
				due_head = pwm_due_q.pop_front();
				if (pwm_ch.pwm_compare !== due_head.pwm) begin
					report($sformatf("beat %0d: pwm_compare %0d, expected %0d",
						due_head.seq, pwm_ch.pwm_compare, due_head.pwm));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((drive_ch.valid && drive_ch.ready) || (pwm_ch.valid && pwm_ch.ready) || cfg_we ||
				!arst_n) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Timeout: no beat moved for %0d cycles.", STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int unsigned ph;
		int unsigned n;
		int unsigned run;
		int unsigned pattern;
		logic dir;
		logic en;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_PROP_GAIN;
		cfg_wdata <= '0;
		drive_ch.valid <= 1'b0;
		drive_ch.direction <= 1'b0;
		drive_ch.drive_enable <= 1'b0;
		kp_q88 = 256;
		ki_q88 = 26;
		integ_lim = 10000;
		pwm_scale_q88 = 2560;
		step_mag = 100;
		integ_q8 = 0;
		src_idle = 1'b1;
		snk_idle = 1'b1;
		hold_req = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < STEER_N; i++) begin
			if (STEER_ROWS[i].kind == ROW_WRITE) begin
				settle();
				write_reg(STEER_ROWS[i].idx, STEER_ROWS[i].data);
			end else begin
				send_beat(STEER_ROWS[i].dir, STEER_ROWS[i].en, STEER_ROWS[i].pinned,
					STEER_ROWS[i].pwm);
			end
		end

		for (ph = 0; ph < PHASES; ph++) begin
			settle();
			// One phase runs with both sides flat out.
			src_idle = (ph != 2);
			snk_idle = (ph != 2);
			write_reg(REG_PROP_GAIN, pick_cfg(65535, 256));
			write_reg(REG_INTEG_GAIN, pick_cfg(65535, 26));
			write_reg(REG_INTEG_LIM, pick_cfg(32767, 10000));
			write_reg(REG_PWM_SCALE, pick_cfg(65535, 2560));
			write_reg(REG_STEP_SIZE, pick_cfg(1023, 100));
			if (ph % 2 == 1) begin
				write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, 16'($urandom));
			end
			if (ph == 4) hold_req = 1'b1;
			n = 0;
			while (n < BEATS_PER_PHASE) begin
				pattern = $urandom_range(9);
				run = $urandom_range(1, 24);
				if (run > BEATS_PER_PHASE - n) run = BEATS_PER_PHASE - n;
				dir = 1'($urandom_range(1));
				en = (pattern < 6);
				repeat (run) begin
					if (pattern >= 8) begin
						dir = 1'($urandom_range(1));
						en = 1'($urandom_range(1));
					end
					send_beat(dir, en, 1'b0, 16'd0);
					n++;
				end
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Run covered %0d drive beats and %0d PWM beats with %0d register writes,",
			beats_sent, results_seen, writes_done);
		$display("over %0d random settings plus the directed table; %0d mismatches.",
			PHASES, mismatches);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
